>>> sv/slfc_pkg.sv
// Shared types and constants of the scheduled light fade controller.
package slfc_pkg;

	// Field and register widths
	localparam int TS_W     = 32;
	localparam int HOUR_W   = 5;
	localparam int MIN_W    = 6;
	localparam int SEC_W    = 6;
	localparam int LEVEL_W  = 8;
	localparam int THR_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Seconds of day reach 31*3600 + 63*60 + 63, fades at most 63*60
	localparam int TIME_W    = 17;
	localparam int FADE_W    = 12;
	localparam int PROD_W    = LEVEL_W + FADE_W;
	localparam int QUO_W     = LEVEL_W;
	localparam int DIV_BIT_W = $clog2(QUO_W);

	localparam int SECS_PER_HOUR = 3600;
	localparam int SECS_PER_MIN  = 60;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SUNRISE_HOUR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUNSET_HOUR  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_MINUTES = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ON_LEVEL     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_LEVEL    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_THR     = 3'd5;

	// Register reset values
	localparam logic [HOUR_W-1:0]  RST_SUNRISE_HOUR = 5'd6;
	localparam logic [HOUR_W-1:0]  RST_SUNSET_HOUR  = 5'd20;
	localparam logic [MIN_W-1:0]   RST_FADE_MINUTES = 6'd30;
	localparam logic [LEVEL_W-1:0] RST_ON_LEVEL     = 8'd255;
	localparam logic [LEVEL_W-1:0] RST_OFF_LEVEL    = 8'd0;
	localparam logic [THR_W-1:0]   RST_LONG_THR     = 16'd1000;

	// Schedule window codes
	localparam logic [1:0] WIN_UP   = 2'd0;
	localparam logic [1:0] WIN_FULL = 2'd1;
	localparam logic [1:0] WIN_DOWN = 2'd2;
	localparam logic [1:0] WIN_OFF  = 2'd3;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic                 capture;
		logic                 time_step;
		logic                 win_step;
		logic                 mul_step;
		logic                 div_step;
		logic [DIV_BIT_W-1:0] div_bit;
		logic                 commit;
	} dp_cmd_t;

endpackage

>>> sv/slfc_ctrl.sv
// Sequencer of the light fade controller: tick steps and output handshake.
module slfc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output slfc_pkg::dp_cmd_t cmd
);
	import slfc_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_TIME = 3'd1;
	localparam logic [2:0] ST_WIN  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0]           state_q;
	logic [DIV_BIT_W-1:0] div_bit_q;
	logic                 out_valid_q;
	logic                 commit;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	// Commit only when the output register is free or being emptied
	assign commit    = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		cmd           = '0;
		cmd.capture   = in_valid && in_ready;
		cmd.time_step = (state_q == ST_TIME);
		cmd.win_step  = (state_q == ST_WIN);
		cmd.mul_step  = (state_q == ST_MUL);
		cmd.div_step  = (state_q == ST_DIV);
		cmd.div_bit   = div_bit_q;
		cmd.commit    = commit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_bit_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_TIME;
					end
				end
				ST_TIME: state_q <= ST_WIN;
				ST_WIN:  state_q <= ST_MUL;
				ST_MUL: begin
					div_bit_q <= DIV_BIT_W'(QUO_W - 1);
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					if (div_bit_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						div_bit_q <= div_bit_q - 1'b1;
					end
				end
				ST_FIN: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> sv/slfc_datapath.sv
// Datapath of the light fade controller: registers, schedule math, divider, button.
module slfc_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  slfc_pkg::dp_cmd_t                cmd,
	input  logic                             cfg_we,
	input  logic [slfc_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  logic [slfc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic [slfc_pkg::TS_W-1:0]        timestamp,
	input  logic [slfc_pkg::HOUR_W-1:0]      clock_hour,
	input  logic [slfc_pkg::MIN_W-1:0]       clock_minute,
	input  logic [slfc_pkg::SEC_W-1:0]       clock_second,
	input  logic                             button_level,
	output logic [slfc_pkg::LEVEL_W-1:0]     light_level
);
	import slfc_pkg::*;

	// Configuration registers
	logic [HOUR_W-1:0]  sunrise_q;
	logic [HOUR_W-1:0]  sunset_q;
	logic [MIN_W-1:0]   fade_min_q;
	logic [LEVEL_W-1:0] on_level_q;
	logic [LEVEL_W-1:0] off_level_q;
	logic [THR_W-1:0]   long_thr_q;

	// Tick state
	logic               auto_q;
	logic               manual_q;
	logic               press_q;
	logic [TS_W-1:0]    press_start_q;
	logic [LEVEL_W-1:0] level_q;

	// Captured item
	logic [TS_W-1:0]    ts_q;
	logic [HOUR_W-1:0]  hour_q;
	logic [MIN_W-1:0]   min_q;
	logic [SEC_W-1:0]   sec_q;
	logic               button_q;

	// Work registers
	logic [TIME_W-1:0]  now_q;
	logic [TIME_W-1:0]  rise_q;
	logic [TIME_W-1:0]  set_q;
	logic [FADE_W-1:0]  fade_q;
	logic [1:0]         win_q;
	logic [FADE_W-1:0]  elapsed_q;
	logic [PROD_W-1:0]  rem_q;
	logic [QUO_W-1:0]   quo_q;

	logic [TIME_W-1:0]  rise_end;
	logic [TIME_W-1:0]  set_end;
	logic [1:0]         win_d;
	logic [PROD_W-1:0]  trial;
	logic [LEVEL_W-1:0] sched_level;
	logic [THR_W-1:0]   press_len;
	logic               is_long;
	logic               auto_d;
	logic               manual_d;
	logic [LEVEL_W-1:0] level_d;

	assign light_level = level_q;

	assign rise_end = rise_q + TIME_W'(fade_q);
	assign set_end  = set_q + TIME_W'(fade_q);

	// First matching window wins
	always_comb begin
		if (now_q >= rise_q && now_q < rise_end) begin
			win_d = WIN_UP;
		end else if (now_q >= rise_end && now_q < set_q) begin
			win_d = WIN_FULL;
		end else if (now_q >= set_q && now_q < set_end) begin
			win_d = WIN_DOWN;
		end else begin
			win_d = WIN_OFF;
		end
	end

	assign trial = PROD_W'(fade_q) << cmd.div_bit;

	always_comb begin
		case (win_q)
			WIN_UP:   sched_level = quo_q;
			WIN_FULL: sched_level = on_level_q;
			WIN_DOWN: sched_level = on_level_q - quo_q;
			default:  sched_level = off_level_q;
		endcase
	end

	assign press_len = THR_W'(ts_q - press_start_q);
	assign is_long   = press_len > long_thr_q;

	always_comb begin
		auto_d   = auto_q;
		manual_d = manual_q;
		level_d  = auto_q ? sched_level : level_q;
		if (button_q && press_q) begin
			if (auto_q) begin
				if (is_long) begin
					auto_d  = 1'b0;
					level_d = manual_q ? on_level_q : off_level_q;
				end
			end else if (is_long) begin
				auto_d = 1'b1;
			end else begin
				manual_d = !manual_q;
				level_d  = !manual_q ? on_level_q : off_level_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sunrise_q     <= RST_SUNRISE_HOUR;
			sunset_q      <= RST_SUNSET_HOUR;
			fade_min_q    <= RST_FADE_MINUTES;
			on_level_q    <= RST_ON_LEVEL;
			off_level_q   <= RST_OFF_LEVEL;
			long_thr_q    <= RST_LONG_THR;
			auto_q        <= 1'b1;
			manual_q      <= 1'b0;
			press_q       <= 1'b0;
			press_start_q <= '0;
			level_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_SUNRISE_HOUR: sunrise_q   <= cfg_wdata[HOUR_W-1:0];
					REG_SUNSET_HOUR:  sunset_q    <= cfg_wdata[HOUR_W-1:0];
					REG_FADE_MINUTES: fade_min_q  <= cfg_wdata[MIN_W-1:0];
					REG_ON_LEVEL:     on_level_q  <= cfg_wdata[LEVEL_W-1:0];
					REG_OFF_LEVEL:    off_level_q <= cfg_wdata[LEVEL_W-1:0];
					REG_LONG_THR:     long_thr_q  <= cfg_wdata[THR_W-1:0];
					default: ;
				endcase
			end
			if (cmd.commit) begin
				auto_q   <= auto_d;
				manual_q <= manual_d;
				level_q  <= level_d;
				if (!button_q && !press_q) begin
					press_start_q <= ts_q;
					press_q       <= 1'b1;
				end else if (button_q && press_q) begin
					press_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ts_q     <= timestamp;
			hour_q   <= clock_hour;
			min_q    <= clock_minute;
			sec_q    <= clock_second;
			button_q <= button_level;
		end
		if (cmd.time_step) begin
			now_q  <= TIME_W'(hour_q) * TIME_W'(SECS_PER_HOUR)
				+ TIME_W'(min_q) * TIME_W'(SECS_PER_MIN) + TIME_W'(sec_q);
			rise_q <= TIME_W'(sunrise_q) * TIME_W'(SECS_PER_HOUR);
			set_q  <= TIME_W'(sunset_q) * TIME_W'(SECS_PER_HOUR);
			fade_q <= FADE_W'(fade_min_q) * FADE_W'(SECS_PER_MIN);
		end
		if (cmd.win_step) begin
			win_q     <= win_d;
			// Only the fade windows use this; there it stays below the fade length
			elapsed_q <= (win_d == WIN_UP) ? FADE_W'(now_q - rise_q)
				: FADE_W'(now_q - set_q);
		end
		if (cmd.mul_step) begin
			rem_q <= PROD_W'(on_level_q) * PROD_W'(elapsed_q);
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			// Restoring division, one quotient bit per step
			if (rem_q >= trial) begin
				rem_q                <= rem_q - trial;
				quo_q[cmd.div_bit]   <= 1'b1;
			end
		end
	end

endmodule

>>> sv/scheduled_light_fade_controller_unit.sv
// Top level of the scheduled light fade controller.
// An input transfer is worked through time, window, multiply, an 8-step restoring divide
// for the fade ratio and commit; a new input is taken only after the previous item commits.
// A new input transfer is taken while the previous result still waits on the output.
// Reset (arst_n low, asynchronous): registers return to their defaults, auto mode,
// manual light off, no press timed, level zero, no result pending.
module scheduled_light_fade_controller_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	// Configuration writes
	input  logic                             cfg_we,
	input  logic [slfc_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  logic [slfc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	// Tick input
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [slfc_pkg::TS_W-1:0]        timestamp,
	input  logic [slfc_pkg::HOUR_W-1:0]      clock_hour,
	input  logic [slfc_pkg::MIN_W-1:0]       clock_minute,
	input  logic [slfc_pkg::SEC_W-1:0]       clock_second,
	input  logic                             button_level,
	// Light level result
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [slfc_pkg::LEVEL_W-1:0]     light_level
);
	import slfc_pkg::*;

	dp_cmd_t cmd;

	// Controller: steps one tick through time-of-day, window select,
	// multiply, divide and commit; holds the result valid until transfer.
	slfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Datapath: configuration, mode and press state, schedule arithmetic.
	// The level register doubles as the output register; it only changes
	// on commit, which waits for the output side to be free.
	slfc_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.timestamp    (timestamp),
		.clock_hour   (clock_hour),
		.clock_minute (clock_minute),
		.clock_second (clock_second),
		.button_level (button_level),
		.light_level  (light_level)
	);

endmodule

>>> sv/slfc_checker.sv
// Port-level checks for the light fade controller, bound to the top level.
module slfc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [slfc_pkg::LEVEL_W-1:0] light_level
);
	import slfc_pkg::*;

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(light_level))
		else $error("result dropped or changed while stalled");

	// One item at a time: busy right after an input transfer
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in work");

	// A new result appears only at the end of an item's work
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result raised without an item in work");

	// Going idle again always leaves a result on the output
	a_idle_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ready) |-> out_valid)
		else $error("item finished without a result");

endmodule

bind scheduled_light_fade_controller_unit slfc_checker u_slfc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.light_level (light_level)
);
